// File: rtl/bps_pkg.sv
// shared types and constants for the beep pattern sequencer
// no dependencies; imported by bps_core and beep_pattern_sequencer_unit
`default_nettype none

package bps_pkg;

  localparam int unsigned TickW  = 10;
  localparam int unsigned RepW   = 8;
  localparam int unsigned ToneW  = 2;
  localparam int unsigned PhaseW = 2;

  // phase codes
  localparam logic [PhaseW-1:0] PH_OFF   = 2'd0;
  localparam logic [PhaseW-1:0] PH_ON    = 2'd1;
  localparam logic [PhaseW-1:0] PH_SHORT = 2'd2;
  localparam logic [PhaseW-1:0] PH_PAUSE = 2'd3;

  localparam logic [TickW-1:0] ON_LIMIT    = 10'd50;
  localparam logic [TickW-1:0] PAUSE_LIMIT = 10'd500;

  // register indexes, taken from paddr[2]
  localparam logic REG_TONE   = 1'b0;
  localparam logic REG_REPEAT = 1'b1;

  localparam logic [ToneW-1:0] TONE_RESET   = 2'd0;
  localparam logic [RepW-1:0]  REPEAT_RESET = 8'd1;

  typedef struct packed {
    logic [ToneW-1:0] tone;
    logic [RepW-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic             beep_enable;
    logic [ToneW-1:0] tone_out;
    logic             busy;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/bps_core.sv
// phase sequencer: one state update per accepted tick
// depends on bps_pkg
`default_nettype none

module bps_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          start_i,
  input  wire bps_pkg::cfg_t cfg_i,
  output bps_pkg::res_t      res_o
);
  import bps_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TickW-1:0]  count_q, count_d, count_inc;
  logic [RepW-1:0]   rep_q, rep_d, rep_inc;
  logic              second_q, second_d;
  logic              active_q, active_d;
  logic [ToneW-1:0]  tone_q, tone_d;
  logic              enable_q, enable_d;

  assign count_inc = count_q + {{(TickW-1){1'b0}}, 1'b1};
  assign rep_inc   = rep_q + {{(RepW-1){1'b0}}, 1'b1};

  always_comb begin
    // start arms before the phase logic runs
    active_d = active_q | start_i;
    phase_d  = phase_q;
    count_d  = count_q;
    rep_d    = rep_q;
    second_d = second_q;
    tone_d   = tone_q;
    enable_d = 1'b0;
    unique case (phase_q)
      PH_OFF: begin
        tone_d = cfg_i.tone;
        if (active_d) begin
          count_d  = '0;
          rep_d    = '0;
          second_d = 1'b0;
          phase_d  = PH_ON;
        end
      end
      PH_ON: begin
        enable_d = 1'b1;
        if (count_inc > ON_LIMIT) begin
          count_d = '0;
          phase_d = second_q ? PH_PAUSE : PH_SHORT;
        end else begin
          count_d = count_inc;
        end
      end
      PH_SHORT: begin
        second_d = 1'b1;
        if (count_inc >= ON_LIMIT) begin
          count_d = '0;
          phase_d = PH_ON;
        end else begin
          count_d = count_inc;
        end
      end
      PH_PAUSE: begin
        if (count_inc > PAUSE_LIMIT) begin
          count_d  = '0;
          second_d = 1'b0;
          rep_d    = rep_inc;
          // a limit of zero still plays one double beep
          if (rep_inc >= cfg_i.limit) begin
            active_d = 1'b0;
            phase_d  = PH_OFF;
          end else begin
            phase_d = PH_ON;
          end
        end else begin
          count_d = count_inc;
        end
      end
      default: begin
        phase_d = PH_OFF;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OFF;
      count_q  <= '0;
      rep_q    <= '0;
      second_q <= 1'b0;
      active_q <= 1'b0;
      tone_q   <= '0;
      enable_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      rep_q    <= rep_d;
      second_q <= second_d;
      active_q <= active_d;
      tone_q   <= tone_d;
      enable_q <= enable_d;
    end
  end

  // result of this tick, taken by the output register on the same edge
  assign res_o.beep_enable = enable_d;
  assign res_o.tone_out    = tone_d;
  assign res_o.busy        = (phase_d != PH_OFF);

endmodule

`default_nettype wire

// File: rtl/beep_pattern_sequencer_unit.sv
// beep pattern sequencer top level: apb registers, tick handshake, result register
// a tick's result is registered and valid in the cycle after the tick beat is accepted
// one tick per cycle unless out_ready_i stalls; the state update is combinational
// the output register frees the input side whenever it is empty or being taken
// reset clears the core and config to the off phase, tone 0 and repeat limit 1
// depends on bps_pkg and bps_core
`default_nettype none

module beep_pattern_sequencer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // tick input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        start_request_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             beep_enable_o,
  output logic [1:0]       tone_out_o,
  output logic             busy_res_o
);
  import bps_pkg::*;

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic step;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tone  <= TONE_RESET;
      cfg_q.limit <= REPEAT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TONE:   cfg_q.tone  <= pwdata[ToneW-1:0];
        REG_REPEAT: cfg_q.limit <= pwdata[RepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TONE:   prdata = {{(32-ToneW){1'b0}}, cfg_q.tone};
      REG_REPEAT: prdata = {{(32-RepW){1'b0}}, cfg_q.limit};
      default:    prdata = '0;
    endcase
  end

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign step       = in_valid_i & in_ready_o;

  bps_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .start_i (start_request_i),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign beep_enable_o = res_q.beep_enable;
  assign tone_out_o    = res_q.tone_out;
  assign busy_res_o    = res_q.busy;

endmodule

`default_nettype wire
